@@ rtl/ccfr_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfr_pkg: shared types and constants for the cubic checksum frame receiver
// Transaction payloads, the cube unit status bundle and the frame constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

  localparam int FRAME_BYTES_DEF = 16;
  localparam int CHECK_BYTES     = 4;
  localparam int PAYLOAD_LEN     = 11;

  localparam logic [7:0] SYNC_BYTE = 8'h0A;
  localparam logic [7:0] CUBE_MOD  = 8'd251;

  localparam logic FRAME_OK  = 1'b0;
  localparam logic FRAME_BAD = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic        frame_status;
    logic [7:0]  next_mode;
    logic [7:0]  current_mode;
    logic [7:0]  fault_cause;
    logic [7:0]  recent_error_count;
    logic [7:0]  total_error_count;
    logic [7:0]  sensor_a;
    logic [7:0]  sensor_b;
    logic [7:0]  sensor_c;
    logic [7:0]  sensor_d;
    logic [15:0] sensor_wide;
  } frame_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cube_status_t;

endpackage

`default_nettype wire

@@ rtl/ccfr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ccfr_stream_if: valid/ready stream channel
// One transaction moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/cubic_checksum_frame_receiver.sv @@
// A summed byte holds the input from accept through the cube unit's two passes to the
//   add into the sum; a check byte does not hold it. The last byte's result and the
//   reopened input both come out of the finish state, which waits for a free result register.
// The input takes no new byte while the bit-serial cube unit works on a summed byte.
// Reset (rst, synchronous, active high): hunting for sync, byte counter zero,
//   result register empty. Sum, check word and payload bytes carry no reset.
// ----------------------------------------------------------------------------
// cubic_checksum_frame_receiver: top level
// Hunts for a newline sync byte, collects a frame, checks a cubic checksum
// against the trailing little-endian word and posts one result per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_checksum_frame_receiver #(
  parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  ccfr_stream_if.sink   rx,
  ccfr_stream_if.source frame
);
  import ccfr_pkg::*;

  localparam int PosW    = $clog2(FRAME_BYTES);
  localparam int PayIdxW = $clog2(PAYLOAD_LEN);

  // first check byte, last byte of the frame and last payload byte
  localparam logic [PosW-1:0] SumEnd  = PosW'(FRAME_BYTES - CHECK_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW-1:0] PayLast = PosW'(PAYLOAD_LEN);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,   // ready for a byte
    ST_CUBE   = 3'b010,   // cube unit running on a summed byte
    ST_FINISH = 3'b100    // compare and post result once the slot is free
  } state_t;

  state_t            state;
  logic              hunting;
  logic [PosW-1:0]   pos;            // index of the next frame byte
  logic [31:0]       running_sum;
  logic [31:0]       received_check; // shifts in from the top: little-endian
  logic [7:0]        payload [PAYLOAD_LEN];
  logic              out_valid;
  frame_result_t     out_data;

  logic              rx_fire;
  logic [7:0]        rx_b;
  logic              is_sync;
  logic              in_sum;
  logic              cube_start;
  logic              out_load;
  logic              frame_ok;
  logic [PosW-1:0]   pos_m1;
  logic [PayIdxW-1:0] pay_idx;
  cube_status_t      cube_st;
  logic [7:0]        cube_term;

  assign rx.ready = (state == ST_IDLE);
  assign rx_fire  = rx.valid && rx.ready;
  assign rx_b     = rx.data.rx_byte;
  assign is_sync  = (rx_b == SYNC_BYTE);
  assign in_sum   = (pos < SumEnd);

  // The sync byte is summed too (frame byte 0).
  assign cube_start = rx_fire && (hunting ? is_sync : in_sum);

  assign pos_m1  = pos - PosW'(1);
  assign pay_idx = pos_m1[PayIdxW-1:0];

  // Result register loads when the previous result is gone or leaving now.
  assign out_load = (state == ST_FINISH) && (!out_valid || frame.ready);
  assign frame_ok = (running_sum == received_check);

  ccfr_cube_unit u_cube (
    .clk    (clk),
    .rst    (rst),
    .start  (cube_start),
    .din    (rx_b),
    .status (cube_st),
    .term   (cube_term)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hunting   <= 1'b1;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (frame.valid && frame.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rx_fire) begin
            if (hunting) begin
              if (is_sync) begin
                hunting <= 1'b0;
                pos     <= PosW'(1);
                state   <= ST_CUBE;
              end
            end else if (pos == LastPos) begin
              // counter stays on the last byte until the result is posted
              state <= ST_FINISH;
            end else begin
              pos <= pos + PosW'(1);
              if (in_sum) begin
                state <= ST_CUBE;
              end
            end
          end
        end
        ST_CUBE: begin
          if (cube_st.done) begin
            state <= ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            hunting   <= 1'b1;
            pos       <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rx_fire && hunting && is_sync) begin
      running_sum <= '0;
    end else if (state == ST_CUBE && cube_st.done) begin
      running_sum <= running_sum + {24'd0, cube_term};
    end

    // four shifts fill the word completely, so no clear is needed
    if (rx_fire && !hunting && !in_sum) begin
      received_check <= {rx_b, received_check[31:8]};
    end

    if (rx_fire && !hunting && pos != '0 && pos <= PayLast) begin
      payload[pay_idx] <= rx_b;
    end

    if (out_load) begin
      out_data.frame_status       <= frame_ok ? FRAME_OK : FRAME_BAD;
      out_data.next_mode          <= frame_ok ? payload[0] : 8'd0;
      out_data.current_mode       <= frame_ok ? payload[1] : 8'd0;
      out_data.fault_cause        <= frame_ok ? payload[2] : 8'd0;
      out_data.recent_error_count <= frame_ok ? payload[3] : 8'd0;
      out_data.total_error_count  <= frame_ok ? payload[4] : 8'd0;
      out_data.sensor_a           <= frame_ok ? payload[5] : 8'd0;
      out_data.sensor_b           <= frame_ok ? payload[6] : 8'd0;
      out_data.sensor_c           <= frame_ok ? payload[7] : 8'd0;
      out_data.sensor_d           <= frame_ok ? payload[8] : 8'd0;
      out_data.sensor_wide        <= frame_ok ? {payload[10], payload[9]} : 16'd0;
    end
  end

  assign frame.valid = out_valid;
  assign frame.data  = out_data;

  // checks
  a_done_in_cube: assert property (@(posedge clk) disable iff (rst)
    cube_st.done |-> state == ST_CUBE)
    else $error("cube unit finished outside the cube state");

  a_cube_running: assert property (@(posedge clk) disable iff (rst)
    state == ST_CUBE |-> (cube_st.busy || cube_st.done))
    else $error("waiting on an idle cube unit");

  a_finish_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> (!hunting && pos == LastPos))
    else $error("frame end reached at the wrong byte");

  a_bad_zeroed: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.data.frame_status == FRAME_BAD)
      |-> (frame.data.sensor_wide == 16'd0 && frame.data.next_mode == 8'd0))
    else $error("failed frame carries data");

endmodule

`default_nettype wire

@@ rtl/ccfr_cube_unit.sv @@
// ----------------------------------------------------------------------------
// ccfr_cube_unit: bit-serial (byte^3 mod 251)
// Two passes of an MSB-first shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfr_cube_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [7:0]              din,
  output      ccfr_pkg::cube_status_t  status,
  output      logic [7:0]              term
);
  import ccfr_pkg::*;

  localparam logic [9:0] ModX1 = {2'b00, CUBE_MOD};
  localparam logic [9:0] ModX2 = {1'b0, CUBE_MOD, 1'b0};

  logic [7:0] base;      // din mod 251
  logic [7:0] mult_sr;   // multiplier bits, MSB first
  logic [7:0] acc;
  logic [2:0] bit_cnt;
  logic       phase;     // 0: squaring, 1: times base
  logic       busy;
  logic       done;

  logic [7:0] din_red;
  logic [9:0] sum_raw;
  logic [7:0] acc_next;

  always_comb begin
    din_red = (din >= CUBE_MOD) ? 8'(din - CUBE_MOD) : din;
    // acc < 251 and base < 251, so sum_raw < 753: at most two subtractions
    sum_raw = {1'b0, acc, 1'b0} + (mult_sr[7] ? {2'b00, base} : 10'd0);
    if (sum_raw >= ModX2) begin
      acc_next = 8'(sum_raw - ModX2);
    end else if (sum_raw >= ModX1) begin
      acc_next = 8'(sum_raw - ModX1);
    end else begin
      acc_next = sum_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase   <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base    <= din_red;
      mult_sr <= din_red;
      acc     <= '0;
    end else if (busy) begin
      if (bit_cnt == 3'd7 && !phase) begin
        // square done: it becomes the multiplier of the second pass
        mult_sr <= acc_next;
        acc     <= '0;
      end else begin
        mult_sr <= {mult_sr[6:0], 1'b0};
        acc     <= acc_next;
      end
    end
  end

  assign status = '{busy: busy, done: done};
  assign term   = acc;

endmodule

`default_nettype wire

@@ tb/frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker: result predictor and scoreboard for the frame receiver
// Watches both channels, tracks sync, checksum and payload per accepted byte,
// and compares each posted frame result against the oldest predicted one.
// ----------------------------------------------------------------------------

module frame_checker #(
  parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rx_valid,
  input  logic                    rx_ready,
  input  ccfr_pkg::rx_item_t      rx_data,
  input  logic                    frame_valid,
  input  logic                    frame_ready,
  input  ccfr_pkg::frame_result_t frame_data,
  output int                      mismatches,
  output int                      outstanding
);
  import ccfr_pkg::*;

  // predictor state
  logic        seeking;
  int          frame_pos;
  logic [31:0] cube_sum;
  logic [31:0] check_word;
  logic [7:0]  body [PAYLOAD_LEN];

  frame_result_t expected_frames [$];
  int            fail_cnt = 0;

  task automatic flag(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t frame check: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) flag($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  always @(posedge clk) begin : track
    frame_result_t want;
    frame_result_t got;
    logic [7:0]    b;
    logic [31:0]   cube;
    if (rst) begin
      seeking    = 1'b1;
      frame_pos  = 0;
      cube_sum   = '0;
      check_word = '0;
      expected_frames.delete();
    end else begin
      // results first: nothing accepted at this edge can post at this edge
      if (frame_valid && frame_ready) begin
        got = frame_data;
        if (expected_frames.size() == 0) begin
          flag($sformatf("result with nothing expected: %h", got));
        end else begin
          want = expected_frames.pop_front();
          compare_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
          compare_field("next_mode", 16'(want.next_mode), 16'(got.next_mode));
          compare_field("current_mode", 16'(want.current_mode), 16'(got.current_mode));
          compare_field("fault_cause", 16'(want.fault_cause), 16'(got.fault_cause));
          compare_field("recent_error_count", 16'(want.recent_error_count),
                        16'(got.recent_error_count));
          compare_field("total_error_count", 16'(want.total_error_count),
                        16'(got.total_error_count));
          compare_field("sensor_a", 16'(want.sensor_a), 16'(got.sensor_a));
          compare_field("sensor_b", 16'(want.sensor_b), 16'(got.sensor_b));
          compare_field("sensor_c", 16'(want.sensor_c), 16'(got.sensor_c));
          compare_field("sensor_d", 16'(want.sensor_d), 16'(got.sensor_d));
          compare_field("sensor_wide", want.sensor_wide, got.sensor_wide);
        end
      end

      if (rx_valid && rx_ready) begin
        b    = rx_data.rx_byte;
        cube = ({24'd0, b} * {24'd0, b} * {24'd0, b}) % 32'(CUBE_MOD);
        if (seeking) begin
          if (b == SYNC_BYTE) begin
            seeking    = 1'b0;
            cube_sum   = cube;
            check_word = '0;
            frame_pos  = 1;
          end
        end else begin
          if (frame_pos >= 1 && frame_pos <= PAYLOAD_LEN) body[frame_pos - 1] = b;
          if (frame_pos < FRAME_BYTES - CHECK_BYTES)
            cube_sum = cube_sum + cube;
          else
            check_word = check_word |
                         (32'(b) << (8 * (frame_pos - (FRAME_BYTES - CHECK_BYTES))));
          if (frame_pos + 1 < FRAME_BYTES) begin
            frame_pos++;
          end else begin
            want = '0;
            if (cube_sum == check_word) begin
              want.frame_status       = FRAME_OK;
              want.next_mode          = body[0];
              want.current_mode       = body[1];
              want.fault_cause        = body[2];
              want.recent_error_count = body[3];
              want.total_error_count  = body[4];
              want.sensor_a           = body[5];
              want.sensor_b           = body[6];
              want.sensor_c           = body[7];
              want.sensor_d           = body[8];
              want.sensor_wide        = {body[10], body[9]};
            end else begin
              // bad checksum zeroes every payload field
              want.frame_status = FRAME_BAD;
            end
            expected_frames.push_back(want);
            seeking    = 1'b1;
            frame_pos  = 0;
            cube_sum   = '0;
            check_word = '0;
          end
        end
      end
    end
    outstanding <= expected_frames.size();
    mismatches  <= fail_cnt;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the cubic checksum frame receiver
// Feeds noise, well-formed and corrupted frames under random source and sink
// idling, forces a long sink stall, and reports the verdict from the checker.
// ----------------------------------------------------------------------------

module tb_top;
  import ccfr_pkg::*;

  localparam int FRAME_LEN   = FRAME_BYTES_DEF;
  localparam int ITEMS       = 1950;   // frame bytes to send in total, noise not counted
  localparam int HOLD_CYCLES = 1500;   // forced sink stall, long enough to back up
  localparam int IDLE_LIMIT  = 20000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 40;     // settle time after the last result

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ccfr_stream_if #(.T(rx_item_t))      rx_if ();
  ccfr_stream_if #(.T(frame_result_t)) frame_if ();

  cubic_checksum_frame_receiver #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_if),
    .frame(frame_if)
  );

  int mismatches;
  int outstanding;

  frame_checker #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_if.valid),
    .rx_ready   (rx_if.ready),
    .rx_data    (rx_if.data),
    .frame_valid(frame_if.valid),
    .frame_ready(frame_if.ready),
    .frame_data (frame_if.data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // idling odds in percent, changed per phase by the stimulus
  int src_pct  = 0;
  int sink_pct = 0;
  // hold-off request: set by the stimulus, picked up and cleared by the sink process
  bit hold_off_req = 1'b0;
  int frame_items  = 0;

  // a gap with pct percent odds; mostly short gaps, rarely a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  // bias toward the corners and toward newline, which must act as plain data
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return SYNC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] cube_term(logic [7:0] b);
    return ({24'd0, b} * {24'd0, b} * {24'd0, b}) % 32'(CUBE_MOD);
  endfunction

  // One rx transaction. valid stays high on return; the next call either
  // replaces the data in the same step or drops valid for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(src_pct);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  // Sync byte, eleven payload bytes, then the little-endian check word.
  // With corrupt set, one byte after the sync gets flipped bits.
  task automatic send_frame(input logic [7:0] body [PAYLOAD_LEN], input bit corrupt);
    logic [7:0]  fbytes [FRAME_LEN];
    logic [31:0] sum;
    int          idx;
    fbytes[0] = SYNC_BYTE;
    for (int i = 0; i < PAYLOAD_LEN; i++) fbytes[i + 1] = body[i];
    sum = '0;
    for (int i = 0; i < FRAME_LEN - CHECK_BYTES; i++) sum = sum + cube_term(fbytes[i]);
    for (int i = 0; i < CHECK_BYTES; i++)
      fbytes[FRAME_LEN - CHECK_BYTES + i] = sum[8 * i +: 8];
    if (corrupt) begin
      idx = $urandom_range(1, FRAME_LEN - 1);
      fbytes[idx] = fbytes[idx] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < FRAME_LEN; i++) send_byte(fbytes[i]);
    frame_items += FRAME_LEN;
  endtask

  // Called right after a transaction: drop valid, then wait until the
  // checker has nothing left outstanding.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Sink side: random ready with gaps, plus one forced long hold-off.
  initial begin : sink_side
    int gap;
    frame_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        frame_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap(sink_pct);
        if (gap > 0) begin
          frame_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        frame_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a correct run never goes this long without a transaction.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] body [PAYLOAD_LEN];
    int         frames;
    int         kind;
    int         noise_len;
    rx_if.valid <= 1'b0;
    rx_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: junk while hunting (near-miss of the sync byte too), then a
    // good frame carrying corner values and a newline inside the payload.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0B);
    body = '{8'h00, 8'hFF, SYNC_BYTE, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
             8'hFF, 8'h00};
    send_frame(body, 1'b0);

    // Random part: mostly well-formed frames, some corrupted, some noise.
    frames = 0;
    while (frame_items < ITEMS) begin
      // new idling mix every 16 loop passes (frames or noise); every third phase runs flat out
      if (frames % 16 == 0) begin
        if ((frames / 16) % 3 == 0) begin
          src_pct  = 0;
          sink_pct = 0;
        end else begin
          src_pct  = $urandom_range(5, 70);
          sink_pct = $urandom_range(5, 70);
        end
      end
      // sink holds off while the source keeps pushing, so the result
      // register backs up and rx ready has to drop
      if (frames == 20) begin
        hold_off_req = 1'b1;
        src_pct      = 0;
      end
      // source pauses until every outstanding result is out
      if (frames == 50 || frames == 90) wait_drained();

      kind = $urandom_range(0, 99);
      for (int i = 0; i < PAYLOAD_LEN; i++) body[i] = pick_byte();
      if (frames == 0 || (kind >= 70 && kind < 85)) begin
        send_frame(body, 1'b1);   // checksum mismatch
      end else if (kind < 70) begin
        send_frame(body, 1'b0);
      end else begin
        // line noise between frames; a stray newline here opens a frame
        // that swallows whatever follows
        noise_len = $urandom_range(1, 6);
        for (int i = 0; i < noise_len; i++) send_byte(pick_byte());
      end
      frames++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
